// File: rtl/md5_hash_engine_assert.svh
// assertion macros shared by the md5 engine
`ifndef MD5_HASH_ENGINE_ASSERT_SVH
`define MD5_HASH_ENGINE_ASSERT_SVH

// condition must hold in the same cycle
`define MD5_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("md5 engine: same-cycle check failed");

// condition must hold in the following cycle
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("md5 engine: next-cycle check failed");

`endif

// File: rtl/md5_pkg.sv
package md5_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LAST_POS   = 6'h3f;
   localparam logic [5:0] PAD_LIMIT  = 6'd56;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [1:0] LAST_WORD  = 2'd3;

   localparam logic [31:0] K_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // commands from the controller to the datapath
   typedef struct packed {
      logic       absorb;
      logic       pad;
      logic       tail;
      logic       init;
      logic       round;
      logic [5:0] round_idx;
      logic       add;
      logic       reinit;
   } md5_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic pos_last;
      logic pos_high;
   } md5_status_type;

   // message word used in a given round
   function automatic logic [3:0] msg_index(input logic [5:0] idx);
      logic [3:0] j;
      logic [3:0] r;
      j = idx[3:0];
      unique case (idx[5:4])
         2'd0: r = j;
         2'd1: r = j * 4'd5 + 4'd1;
         2'd2: r = j * 4'd3 + 4'd5;
         2'd3: r = j * 4'd7;
         default: r = j;
      endcase
      return r;
   endfunction

   // nonlinear mix of the round group
   function automatic logic [31:0] round_mix(input logic [1:0] grp, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      unique case (grp)
         2'd0: f = (b & c) | (~b & d);
         2'd1: f = (b & d) | (c & ~d);
         2'd2: f = b ^ c ^ d;
         2'd3: f = c ^ (b | ~d);
         default: f = b ^ c ^ d;
      endcase
      return f;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] t;
      t = {x, x} << n;
      return t[63:32];
   endfunction

endpackage

// File: rtl/md5_datapath.sv
module md5_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  md5_pkg::md5_cmd_type    cmd,
   output md5_pkg::md5_status_type status,
   input  logic [7:0]             data_byte,
   input  logic [1:0]             word_sel,
   output logic [31:0]            digest_word
);

   logic [31:0] chain_ff [4];
   logic [31:0] buf_ff   [16];
   logic [31:0] buf_in   [16];
   logic [63:0] count_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [5:0]  pos;
   logic [31:0] t_sum;
   logic [31:0] nb;

   assign pos             = count_ff[8:3];
   assign status.pos_last = (pos == md5_pkg::LAST_POS);
   assign status.pos_high = (pos >= md5_pkg::PAD_LIMIT);

   // block buffer update: byte write, padding, count tail
   always_comb begin
      logic [5:0] bidx;
      bidx = '0;
      for (int w = 0; w < 16; w++) begin
         buf_in[w] = buf_ff[w];
      end
      for (int w = 0; w < 16; w++) begin
         for (int k = 0; k < 4; k++) begin
            bidx = 6'(w * 4 + k);
            if (cmd.absorb && bidx == pos) begin
               buf_in[w][8*k +: 8] = data_byte;
            end
            if (cmd.pad) begin
               if (bidx == pos) begin
                  buf_in[w][8*k +: 8] = md5_pkg::PAD_BYTE;
               end else if (bidx > pos) begin
                  buf_in[w][8*k +: 8] = 8'h00;
               end
            end
            if (cmd.tail) begin
               buf_in[w][8*k +: 8] = 8'h00;
            end
         end
      end
      if ((cmd.pad && !status.pos_high) || cmd.tail) begin
         buf_in[14] = count_ff[31:0];
         buf_in[15] = count_ff[63:32];
      end
   end

   always_ff @(posedge clock) begin
      for (int w = 0; w < 16; w++) begin
         buf_ff[w] <= buf_in[w];
      end
   end

   // one md5 round
   always_comb begin
      t_sum = a_ff + md5_pkg::round_mix(cmd.round_idx[5:4], b_ff, c_ff, d_ff)
            + buf_ff[md5_pkg::msg_index(cmd.round_idx)]
            + md5_pkg::K_TABLE[cmd.round_idx];
      nb = b_ff + md5_pkg::rotl32(t_sum,
                     md5_pkg::ROT_TABLE[{cmd.round_idx[5:4], cmd.round_idx[1:0]}]);
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (cmd.round) begin
         a_ff <= d_ff;
         b_ff <= nb;
         c_ff <= b_ff;
         d_ff <= c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         count_ff    <= '0;
         chain_ff[0] <= md5_pkg::INIT_A;
         chain_ff[1] <= md5_pkg::INIT_B;
         chain_ff[2] <= md5_pkg::INIT_C;
         chain_ff[3] <= md5_pkg::INIT_D;
      end else begin
         if (cmd.absorb) begin
            count_ff <= count_ff + 64'd8;
         end
         if (cmd.add) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
         end
      end
   end

   assign digest_word = chain_ff[word_sel];

endmodule

// File: rtl/md5_control.sv
module md5_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             word_sel,
   output logic                   last_word,
   output md5_pkg::md5_cmd_type    cmd,
   input  md5_pkg::md5_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_ROUND, S_ADD, S_TAIL, S_OUT
   } state_type;

   state_type  state_ff;
   logic [5:0] round_ff;
   logic [1:0] word_ff;
   logic       emit_ff;
   logic       second_ff;
   logic       take;

   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_OUT);
   assign word_sel  = word_ff;
   assign last_word = (word_ff == md5_pkg::LAST_WORD);

   always_comb begin
      cmd.absorb    = take && !req_cmd;
      cmd.pad       = take && req_cmd;
      cmd.tail      = (state_ff == S_TAIL);
      cmd.init      = (state_ff == S_LOAD);
      cmd.round     = (state_ff == S_ROUND);
      cmd.round_idx = round_ff;
      cmd.add       = (state_ff == S_ADD);
      cmd.reinit    = rsp_valid && !rsp_stall && last_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         round_ff  <= '0;
         word_ff   <= '0;
         emit_ff   <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (take && req_cmd) begin
                  emit_ff   <= !status.pos_high;
                  second_ff <= status.pos_high;
                  state_ff  <= S_LOAD;
               end else if (take && status.pos_last) begin
                  emit_ff   <= 1'b0;
                  second_ff <= 1'b0;
                  state_ff  <= S_LOAD;
               end
            end
            S_LOAD: begin
               round_ff <= '0;
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               round_ff <= round_ff + 6'd1;
               if (round_ff == md5_pkg::LAST_ROUND) begin
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               if (emit_ff) begin
                  word_ff  <= '0;
                  state_ff <= S_OUT;
               end else if (second_ff) begin
                  state_ff <= S_TAIL;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_TAIL: begin
               emit_ff   <= 1'b1;
               second_ff <= 1'b0;
               state_ff  <= S_LOAD;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  word_ff <= word_ff + 2'd1;
                  if (last_word) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/md5_hash_engine.sv
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_cmd, req_data_byte
// rsp       out        rsp_valid / rsp_stall   rsp_digest_word, rsp_word_index, rsp_last_word
//
// an absorb item writes one byte into the block buffer; the 64th byte of a block then starts
// compression (load, 64 rounds at one round per cycle, chaining add)
// a finish item pads and compresses one block, or two (the second holding only zeros and the
// bit count) when the byte position is 56 or more, then four digest words go out while rsp_stall is low
// the single round unit does all compression; req_stall is high while it runs
// synchronous active-high reset restores the initial chaining words and a zero count
module md5_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   // command and status between controller and datapath
   md5_pkg::md5_cmd_type    cmd;
   md5_pkg::md5_status_type status;
   logic [1:0]              word_sel;

   // sequencer: byte intake, round count, padding phases, digest output
   md5_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .word_sel  (word_sel),
      .last_word (rsp_last_word),
      .cmd       (cmd),
      .status    (status)
   );

   // block buffer, bit count, chaining words and the round unit
   md5_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .data_byte   (req_data_byte),
      .word_sel    (word_sel),
      .digest_word (rsp_digest_word)
   );

   assign rsp_word_index = word_sel;

`include "md5_hash_engine_assert.svh"

   // no new item is taken while the digest is being delivered
   `MD5_ASSERT_SAME(a_out_blocks_in, clock, reset, rsp_valid, req_stall)
   // last flag marks exactly the fourth word
   `MD5_ASSERT_SAME(a_last_flag, clock, reset, rsp_valid, rsp_last_word == (rsp_word_index == md5_pkg::LAST_WORD))
   // a finish item starts compression right away
   `MD5_ASSERT_NEXT(a_finish_busy, clock, reset, req_valid && !req_stall && req_cmd, req_stall)
   // output ends after the fourth word is taken
   `MD5_ASSERT_NEXT(a_out_ends, clock, reset, rsp_valid && !rsp_stall && rsp_last_word, !rsp_valid)

endmodule
